// ===== rtl/lpr_pkg.sv =====
// Package for the line pixel rasterizer: payload structs, register indexes
// and the configuration bundle shared by all lpr_* modules. No dependencies.
`default_nettype none

package lpr_pkg;

	localparam int COORD_BITS = 12;
	localparam int ADDR_BITS  = 48;
	localparam int COLOR_BITS = 32;
	localparam int SIZE_BITS  = 13;
	localparam int PITCH_BITS = 14;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 48;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] CFG_FB_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FB_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_PIXELS   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_ADDRESS = 2'd3;

	// Request kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	typedef struct packed {
		logic                  req_type;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
		logic [COLOR_BITS-1:0] color;
	} line_req_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pix_x;
		logic [COORD_BITS-1:0] pix_y;
		logic [ADDR_BITS-1:0]  pix_addr;
		logic [COLOR_BITS-1:0] pix_color;
		logic                  last_pixel;
	} pix_out_t;

	// Pixel position leaving the stepping stage, before address generation
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} pix_pos_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0]  fb_width;
		logic [SIZE_BITS-1:0]  fb_height;
		logic [PITCH_BITS-1:0] row_pixels;
		logic [ADDR_BITS-1:0]  base_address;
	} lpr_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lpr_cfg.sv =====
// Configuration register file of the line pixel rasterizer.
// Depends on lpr_pkg for register indexes and the lpr_cfg_t bundle.
`default_nettype none

module lpr_cfg import lpr_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
	output lpr_cfg_t                      cfg
);

	lpr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_width     <= SIZE_BITS'(1024);
			cfg_q.fb_height    <= SIZE_BITS'(768);
			cfg_q.row_pixels   <= PITCH_BITS'(1024);
			cfg_q.base_address <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FB_WIDTH:     cfg_q.fb_width     <= cfg_wdata[SIZE_BITS-1:0];
				CFG_FB_HEIGHT:    cfg_q.fb_height    <= cfg_wdata[SIZE_BITS-1:0];
				CFG_ROW_PIXELS:   cfg_q.row_pixels   <= cfg_wdata[PITCH_BITS-1:0];
				CFG_BASE_ADDRESS: cfg_q.base_address <= cfg_wdata[ADDR_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/lpr_step.sv =====
// Bresenham stepping stage: line setup on start, one position per step tick.
// Depends on lpr_pkg; feeds pix_pos_t entries to lpr_addr.
`default_nettype none

module lpr_step import lpr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire lpr_cfg_t  cfg,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire line_req_t req,
	output logic           pos_valid,
	input  wire logic      pos_ready,
	output pix_pos_t       pos
);

	localparam int ERR_BITS = COORD_BITS + 1;

	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, dx_mag_q, dy_mag_q, steps_left_q;
	logic [ERR_BITS-1:0]   err_acc_q;
	logic                  step_x_neg_q, step_y_neg_q, x_major_q, line_active_q;
	logic [COLOR_BITS-1:0] line_color_q;

	logic     pos_valid_s1;
	pix_pos_t pos_s1;

	function automatic logic [COORD_BITS-1:0] clamp_coord(
		input logic [COORD_BITS-1:0] v,
		input logic [SIZE_BITS-1:0]  size
	);
		logic [COORD_BITS-1:0] r;
		if (size == '0)
			r = '0;
		else if (SIZE_BITS'(v) >= size)
			r = COORD_BITS'(size - SIZE_BITS'(1));
		else
			r = v;
		return r;
	endfunction

	// Setup of a new line
	logic [COORD_BITS-1:0] x0, y0, x1, y1, dx_new, dy_new, major_new;
	logic                  x_neg_new, y_neg_new, x_major_new;

	always_comb begin
		x0 = clamp_coord(req.start_x, cfg.fb_width);
		y0 = clamp_coord(req.start_y, cfg.fb_height);
		x1 = clamp_coord(req.end_x, cfg.fb_width);
		y1 = clamp_coord(req.end_y, cfg.fb_height);
		x_neg_new   = x1 < x0;
		y_neg_new   = y1 < y0;
		dx_new      = x_neg_new ? x0 - x1 : x1 - x0;
		dy_new      = y_neg_new ? y0 - y1 : y1 - y0;
		x_major_new = dx_new >= dy_new;
		major_new   = x_major_new ? dx_new : dy_new;
	end

	// One Bresenham step from the current state
	logic [ERR_BITS-1:0]   err_sum, err_next, major_e;
	logic                  minor_move;
	logic [COORD_BITS-1:0] x_next, y_next, x_mv, y_mv;

	always_comb begin
		err_sum    = err_acc_q + ERR_BITS'(x_major_q ? dy_mag_q : dx_mag_q);
		major_e    = ERR_BITS'(x_major_q ? dx_mag_q : dy_mag_q);
		minor_move = err_sum >= major_e;
		err_next   = minor_move ? err_sum - major_e : err_sum;
		x_mv       = step_x_neg_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
		y_mv       = step_y_neg_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
		x_next     = (x_major_q || minor_move) ? x_mv : cur_x_q;
		y_next     = (!x_major_q || minor_move) ? y_mv : cur_y_q;
	end

	logic take, do_start, do_step, last_step;

	assign req_ready = !pos_valid_s1 || pos_ready;
	assign take      = req_valid && req_ready;
	assign do_start  = take && (req.req_type == REQ_START);
	assign do_step   = take && (req.req_type == REQ_STEP) && line_active_q;
	assign last_step = steps_left_q == COORD_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			err_acc_q     <= '0;
			steps_left_q  <= '0;
			dx_mag_q      <= '0;
			dy_mag_q      <= '0;
			step_x_neg_q  <= 1'b0;
			step_y_neg_q  <= 1'b0;
			x_major_q     <= 1'b0;
			line_active_q <= 1'b0;
			line_color_q  <= '0;
		end else if (do_start) begin
			cur_x_q       <= x0;
			cur_y_q       <= y0;
			err_acc_q     <= ERR_BITS'(major_new >> 1);
			steps_left_q  <= major_new;
			dx_mag_q      <= dx_new;
			dy_mag_q      <= dy_new;
			step_x_neg_q  <= x_neg_new;
			step_y_neg_q  <= y_neg_new;
			x_major_q     <= x_major_new;
			line_active_q <= major_new != '0;
			line_color_q  <= req.color;
		end else if (do_step) begin
			cur_x_q       <= x_next;
			cur_y_q       <= y_next;
			err_acc_q     <= err_next;
			steps_left_q  <= steps_left_q - COORD_BITS'(1);
			line_active_q <= !last_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_valid_s1 <= 1'b0;
		else if (req_ready)
			pos_valid_s1 <= do_step;
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			pos_s1.x     <= x_next;
			pos_s1.y     <= y_next;
			pos_s1.color <= line_color_q;
			pos_s1.last  <= last_step;
		end
	end

	assign pos_valid = pos_valid_s1;
	assign pos       = pos_s1;

endmodule

`default_nettype wire

// ===== rtl/lpr_addr.sv =====
// Address stage: byte address of each pixel and the output register.
// Depends on lpr_pkg; takes pix_pos_t entries from lpr_step.
`default_nettype none

module lpr_addr import lpr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire lpr_cfg_t cfg,
	input  wire logic     pos_valid,
	output logic          pos_ready,
	input  wire pix_pos_t pos,
	output logic          pix_valid,
	input  wire logic     pix_ready,
	output pix_out_t      pix
);

	localparam int PROD_BITS = COORD_BITS + PITCH_BITS;
	localparam int OFS_BITS  = PROD_BITS + 1;

	logic [PROD_BITS-1:0] row_ofs;
	logic [OFS_BITS-1:0]  pix_ofs;
	logic [ADDR_BITS-1:0] addr;

	// base + 4 * (x + y * row_pixels), wrapping at the address width
	always_comb begin
		row_ofs = PROD_BITS'(pos.y) * PROD_BITS'(cfg.row_pixels);
		pix_ofs = OFS_BITS'(row_ofs) + OFS_BITS'(pos.x);
		addr    = cfg.base_address + ADDR_BITS'({pix_ofs, 2'b00});
	end

	logic     pix_valid_s2;
	pix_out_t pix_s2;

	assign pos_ready = !pix_valid_s2 || pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pix_valid_s2 <= 1'b0;
		else if (pos_ready)
			pix_valid_s2 <= pos_valid;
	end

	always_ff @(posedge clk) begin
		if (pos_ready && pos_valid) begin
			pix_s2.pix_x      <= pos.x;
			pix_s2.pix_y      <= pos.y;
			pix_s2.pix_addr   <= addr;
			pix_s2.pix_color  <= pos.color;
			pix_s2.last_pixel <= pos.last;
		end
	end

	assign pix_valid = pix_valid_s2;
	assign pix       = pix_s2;

endmodule

`default_nettype wire

// ===== rtl/line_pixel_rasterizer.sv =====
// Line pixel rasterizer, top level. Instantiates lpr_cfg, lpr_step and
// lpr_addr; depends on lpr_pkg for payload structs and register indexes.
`default_nettype none

// A start request (req_type 0) clamps both endpoints to fb_width/fb_height,
// latches the color and sets up an integer Bresenham walk; it produces no
// pixel. Each following step request (req_type 1) produces one pixel write:
// x, y, byte address base_address + 4*x + 4*y*row_pixels (mod 2^48) and the
// color, with last_pixel set on the line's end point. A line plots
// max(|dx|,|dy|) pixels after its start point; a zero-length line and steps
// on an idle rasterizer produce nothing. A new start replaces any line still
// in progress. Throughput is one request per clock while the output does not
// stall: the Bresenham update is a single add and compare against registered
// state. A pixel passes the stepping register, then the address multiply-add
// into the output register. Both stages hold under back-pressure; a pixel
// waiting at the output lets one more request in before req_ready drops.
// Write the configuration registers only while no pixel is in flight.

module line_pixel_rasterizer import lpr_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration write port
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
	// request channel
	input  wire logic                     req_valid,
	output logic                          req_ready,
	input  wire line_req_t                req,
	// pixel channel
	output logic                          pix_valid,
	input  wire logic                     pix_ready,
	output pix_out_t                      pix
);

	lpr_cfg_t cfg;
	logic     pos_valid, pos_ready;
	pix_pos_t pos;

	// Hold the register file; writes land at once
	lpr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Advance the Bresenham state, one position per step request
	lpr_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.pos_valid (pos_valid),
		.pos_ready (pos_ready),
		.pos       (pos)
	);

	// Form the byte address and hold the pixel until taken
	lpr_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pos_valid (pos_valid),
		.pos_ready (pos_ready),
		.pos       (pos),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

endmodule

`default_nettype wire

// ===== dv/line_pixel_rasterizer_test.sv =====
// Self-checking testbench for line_pixel_rasterizer: drives line requests under random
// sender gaps and receiver stalls, and predicts every pixel write with its own Bresenham walk.
// Depends on rtl/lpr_pkg.sv and the rasterizer RTL; reads no files.

module line_pixel_rasterizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lpr_pkg::*;

	localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
	localparam int RANDOM_ITEMS = 1000;
	localparam int PHASE_ITEMS  = 300;
	// a pixel passes the stepping and output registers; leave slack for a start in flight
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int MAX_REPORTS  = 40;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOPPY} rx_mode_e;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                     req_valid = 1'b0;
	logic                     req_ready;
	line_req_t                req = '0;
	logic                     pix_valid;
	logic                     pix_ready = 1'b0;
	pix_out_t                 pix;

	line_pixel_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the registers, starting at their reset values
	// ------------------------------------------------------------------
	logic [SIZE_BITS-1:0]  vis_w = 13'd1024;
	logic [SIZE_BITS-1:0]  vis_h = 13'd768;
	logic [PITCH_BITS-1:0] pitch = 14'd1024;
	logic [ADDR_BITS-1:0]  fb_base = '0;

	// Line walker state, all zero and idle after reset
	logic [COORD_BITS-1:0] walk_x = '0;
	logic [COORD_BITS-1:0] walk_y = '0;
	logic [12:0]           walk_err = '0;
	logic [12:0]           walk_left = '0;
	logic [COORD_BITS-1:0] span_x = '0;
	logic [COORD_BITS-1:0] span_y = '0;
	logic                  x_back = 1'b0;
	logic                  y_back = 1'b0;
	logic                  walk_xmajor = 1'b0;
	logic                  walk_on = 1'b0;
	logic [COLOR_BITS-1:0] walk_color = '0;

	// Pixel writes predicted but not yet seen on the output, oldest first
	pix_out_t pixel_queue[$];

	int mismatches = 0;
	int pixels_checked = 0;
	int lines_started = 0;
	int useful_reqs = 0;
	int requests_seen = 0;
	int cfg_writes = 0;
	int cycles = 0;

	// Sender burst bookkeeping: req_live mirrors the value scheduled on req_valid
	int burst_left = 0;
	bit req_live = 1'b0;

	rx_mode_e rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       choppy_left = 0;
	logic     choppy_lvl = 1'b0;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Clamp one coordinate to the visible size; a zero size pins it to 0.
	function automatic logic [COORD_BITS-1:0] clip(input logic [COORD_BITS-1:0] c,
			input logic [SIZE_BITS-1:0] size);
		if (size == '0)
			return '0;
		if ({1'b0, c} >= size)
			return size[COORD_BITS-1:0] - COORD_BITS'(1);
		return c;
	endfunction

	// Advance the walker by one accepted request and queue the pixel it writes.
	task automatic rasterize(input line_req_t r);
		logic [COORD_BITS-1:0] x0, y0, x1, y1;
		logic [63:0]           ax, ay, ap, sum;
		pix_out_t              p;
		requests_seen++;
		if (r.req_type == REQ_START) begin
			x0 = clip(r.start_x, vis_w);
			y0 = clip(r.start_y, vis_h);
			x1 = clip(r.end_x, vis_w);
			y1 = clip(r.end_y, vis_h);
			x_back = x1 < x0;
			y_back = y1 < y0;
			span_x = x_back ? x0 - x1 : x1 - x0;
			span_y = y_back ? y0 - y1 : y1 - y0;
			walk_xmajor = span_x >= span_y;
			walk_left = {1'b0, (walk_xmajor ? span_x : span_y)};
			walk_err = {1'b0, ((walk_xmajor ? span_x : span_y) >> 1)};
			walk_x = x0;
			walk_y = y0;
			walk_color = r.color;
			walk_on = walk_left != '0;
			lines_started++;
			useful_reqs++;
		end else if (walk_on) begin
			useful_reqs++;
			if (walk_xmajor) begin
				walk_err = walk_err + {1'b0, span_y};
				if (walk_err >= {1'b0, span_x}) begin
					walk_err = walk_err - {1'b0, span_x};
					walk_y = y_back ? walk_y - COORD_BITS'(1) : walk_y + COORD_BITS'(1);
				end
				walk_x = x_back ? walk_x - COORD_BITS'(1) : walk_x + COORD_BITS'(1);
			end else begin
				walk_err = walk_err + {1'b0, span_x};
				if (walk_err >= {1'b0, span_y}) begin
					walk_err = walk_err - {1'b0, span_y};
					walk_x = x_back ? walk_x - COORD_BITS'(1) : walk_x + COORD_BITS'(1);
				end
				walk_y = y_back ? walk_y - COORD_BITS'(1) : walk_y + COORD_BITS'(1);
			end
			walk_left = walk_left - 13'd1;
			if (walk_left == '0)
				walk_on = 1'b0;
			ax = 64'(walk_x);
			ay = 64'(walk_y);
			ap = 64'(pitch);
			sum = {16'd0, fb_base} + (ax << 2) + ((ay * ap) << 2);
			p.pix_x = walk_x;
			p.pix_y = walk_y;
			p.pix_addr = sum[ADDR_BITS-1:0];
			p.pix_color = walk_color;
			p.last_pixel = !walk_on;
			pixel_queue.push_back(p);
		end
	endtask

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Check every pixel handed over, then fold in the request taken at the same edge.
	// A request passes the stepping and output registers before the output, so this order is safe.
	always @(posedge clk) begin : check_and_predict
		pix_out_t want;
		if (arst_n) begin
			if (pix_valid && pix_ready) begin
				if (pixel_queue.size() == 0) begin
					report_mismatch($sformatf("pixel (%0d,%0d) with nothing expected",
						pix.pix_x, pix.pix_y));
				end else begin
					want = pixel_queue.pop_front();
					if (pix.pix_x !== want.pix_x)
						report_mismatch($sformatf("pixel %0d pix_x got %0d want %0d",
							pixels_checked, pix.pix_x, want.pix_x));
					if (pix.pix_y !== want.pix_y)
						report_mismatch($sformatf("pixel %0d pix_y got %0d want %0d",
							pixels_checked, pix.pix_y, want.pix_y));
					if (pix.pix_addr !== want.pix_addr)
						report_mismatch($sformatf("pixel %0d pix_addr got %h want %h",
							pixels_checked, pix.pix_addr, want.pix_addr));
					if (pix.pix_color !== want.pix_color)
						report_mismatch($sformatf("pixel %0d pix_color got %h want %h",
							pixels_checked, pix.pix_color, want.pix_color));
					if (pix.last_pixel !== want.last_pixel)
						report_mismatch($sformatf("pixel %0d last_pixel got %b want %b",
							pixels_checked, pix.last_pixel, want.last_pixel));
					pixels_checked++;
				end
			end
			if (req_valid && req_ready)
				rasterize(req);
		end
	end

	// Hard stop in case a handshake never completes or pixels go missing.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels still outstanding",
				cycles, pixel_queue.size());
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: switch between always-ready, coin-flip and choppy stretches
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 2));
			rx_left = int'($urandom_range(20, 200));
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: begin
				pix_ready <= 1'b1;
			end
			RX_COIN: begin
				pix_ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				// long stalls broken by short windows of readiness
				if (choppy_left == 0) begin
					choppy_lvl = !choppy_lvl;
					choppy_left = choppy_lvl ? int'($urandom_range(1, 4))
						: int'($urandom_range(1, 8));
				end
				choppy_left--;
				pix_ready <= choppy_lvl;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sender. All tasks below are entered and left at a falling edge.
	// ------------------------------------------------------------------

	// Offer one request and hold it until taken. Bursts of random length are
	// separated by random gaps; a long burst now and then gives gap-free runs.
	task automatic send_req(input line_req_t r);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(60, 150))
				: int'($urandom_range(1, 20));
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= r;
		req_live = 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
		// drop valid only when the burst is over, so back-to-back requests keep it high
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			req_live = 1'b0;
		end
	endtask

	// Close the current burst so nothing is re-offered while the caller waits.
	task automatic end_burst();
		if (req_live) begin
			req_valid <= 1'b0;
			req_live = 1'b0;
		end
		burst_left = 0;
	endtask

	// Step tick; the coordinate and color fields are don't-care and carry noise.
	task automatic send_step();
		line_req_t r;
		r.req_type = REQ_STEP;
		r.start_x = COORD_BITS'($urandom_range(0, COORD_MAX));
		r.start_y = COORD_BITS'($urandom_range(0, COORD_MAX));
		r.end_x = COORD_BITS'($urandom_range(0, COORD_MAX));
		r.end_y = COORD_BITS'($urandom_range(0, COORD_MAX));
		r.color = $urandom;
		send_req(r);
	endtask

	// Start a line, then tick it: its full length plus trailing steps (negative
	// cuts it short so the next start replaces it), never more than cap ticks.
	task automatic draw_line(input logic [COORD_BITS-1:0] x0, y0, x1, y1,
			input logic [COLOR_BITS-1:0] col, input int trailing, input int cap);
		line_req_t r;
		int        n;
		r.req_type = REQ_START;
		r.start_x = x0;
		r.start_y = y0;
		r.end_x = x1;
		r.end_y = y1;
		r.color = col;
		send_req(r);
		// the walker already holds this line's length once the start is taken
		n = int'(walk_left) + trailing;
		if (n > cap)
			n = cap;
		repeat (n) send_step();
	endtask

	// Wait out every expected pixel plus the pipeline depth, so the block is idle.
	task automatic settle();
		end_burst();
		while (pixel_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_FB_WIDTH:     vis_w = val[SIZE_BITS-1:0];
			CFG_FB_HEIGHT:    vis_h = val[SIZE_BITS-1:0];
			CFG_ROW_PIXELS:   pitch = val[PITCH_BITS-1:0];
			CFG_BASE_ADDRESS: fb_base = val[ADDR_BITS-1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic set_screen(input logic [SIZE_BITS-1:0] w, h,
			input logic [PITCH_BITS-1:0] row, input logic [ADDR_BITS-1:0] base);
		settle();
		write_cfg(CFG_FB_WIDTH, CFG_DATA_BITS'(w));
		write_cfg(CFG_FB_HEIGHT, CFG_DATA_BITS'(h));
		write_cfg(CFG_ROW_PIXELS, CFG_DATA_BITS'(row));
		write_cfg(CFG_BASE_ADDRESS, CFG_DATA_BITS'(base));
	endtask

	// ------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------
	function automatic logic [COORD_BITS-1:0] pick_coord(input logic [SIZE_BITS-1:0] size);
		int lim;
		lim = (size == '0) ? 1 : ((int'(size) > COORD_MAX + 1) ? COORD_MAX + 1 : int'(size));
		return COORD_BITS'($urandom_range(0, lim - 1));
	endfunction

	// A point close by, so most lines are short; may land past the screen edge.
	function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] c);
		int d, v;
		d = int'($urandom_range(0, 24));
		v = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic logic [SIZE_BITS-1:0] random_size();
		case ($urandom_range(0, 9))
			0: return SIZE_BITS'($urandom_range(0, 8));
			1: return SIZE_BITS'($urandom_range(COORD_MAX + 2, (1 << SIZE_BITS) - 1));
			default: return SIZE_BITS'($urandom_range(16, COORD_MAX + 1));
		endcase
	endfunction

	task automatic random_line();
		logic [COORD_BITS-1:0] x0, y0, x1, y1;
		int                    trailing, cap;
		cap = 1 << 13;
		if ($urandom_range(0, 9) == 0) begin
			// endpoints anywhere in the field range; tick only the head of the line
			x0 = COORD_BITS'($urandom_range(0, COORD_MAX));
			y0 = COORD_BITS'($urandom_range(0, COORD_MAX));
			x1 = COORD_BITS'($urandom_range(0, COORD_MAX));
			y1 = COORD_BITS'($urandom_range(0, COORD_MAX));
			cap = int'($urandom_range(0, 16));
		end else begin
			x0 = pick_coord(vis_w);
			y0 = pick_coord(vis_h);
			x1 = near_coord(x0);
			y1 = near_coord(y0);
		end
		case ($urandom_range(0, 19))
			0, 1, 2, 3: trailing = 0 - int'($urandom_range(1, 12));
			4: begin
				// stray ticks first: ignored if the previous line is finished
				trailing = 0;
				repeat ($urandom_range(1, 3)) send_step();
			end
			default: trailing = int'($urandom_range(0, 2));
		endcase
		draw_line(x0, y0, x1, y1, $urandom, trailing, cap);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset configuration: an idle tick, a zero-length line, clamped endpoints,
	// both directions, straight lines and a line replaced mid-walk.
	task automatic test_directed();
		send_step();
		draw_line(12'd5, 12'd5, 12'd5, 12'd5, 32'h1234_5678, 1, 1 << 13);
		draw_line(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 12'd1020, 12'd760,
			32'hFFFF_FFFF, 1, 1 << 13);
		draw_line(12'd0, 12'd0, 12'd3, 12'd0, 32'h0000_0000, 0, 1 << 13);
		draw_line(12'd10, 12'd10, 12'd14, 12'd14, 32'hA5A5_A5A5, -2, 1 << 13);
		draw_line(12'd2, 12'd9, 12'd2, 12'd5, 32'h5A5A_5A5A, 0, 1 << 13);
	endtask

	// Register extremes: zero and one sized screens, oversize screens, pitch
	// extremes, address wrap at the top of the space, and the head of one
	// screen-wide line.
	task automatic test_register_extremes();
		set_screen(13'd0, 13'd4096, 14'd8192, 48'hFFFF_FFFF_FFFF);
		repeat (8) random_line();
		set_screen(13'd4096, 13'd0, 14'd1, 48'h0);
		repeat (8) random_line();
		set_screen(13'd1, 13'd1, 14'd0, 48'h8000_0000_0001);
		repeat (6) random_line();
		set_screen(13'd8191, 13'd8191, 14'd16383, 48'hFFFF_FFFF_FFFF);
		draw_line(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX - 9),
			COORD_BITS'(COORD_MAX - 20), 32'hFFFF_FFFF, 1, 1 << 13);
		draw_line(COORD_BITS'(COORD_MAX), 12'd100, 12'd0, 12'd3000, 32'h0F0F_0F0F, 1, 256);
		repeat (6) random_line();
	endtask

	// Mostly short lines with random content over a string of random screens.
	task automatic test_random_lines();
		logic [63:0] r64;
		logic [47:0] base;
		int          goal, phase_goal;
		goal = useful_reqs + RANDOM_ITEMS;
		while (useful_reqs < goal) begin
			r64 = {$urandom, $urandom};
			case ($urandom_range(0, 3))
				0: base = '0;
				1: base = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 65535));
				default: base = r64[47:0];
			endcase
			set_screen(random_size(), random_size(),
				($urandom_range(0, 9) == 0) ? PITCH_BITS'($urandom_range(0, (1 << PITCH_BITS) - 1))
				: PITCH_BITS'($urandom_range(1, 8192)), base);
			phase_goal = useful_reqs + PHASE_ITEMS;
			while (useful_reqs < phase_goal && useful_reqs < goal)
				random_line();
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_register_extremes();
		test_random_lines();
		settle();
		$display("run covered %0d requests (%0d line starts, %0d useful), %0d register writes",
			requests_seen, lines_started, useful_reqs, cfg_writes);
		$display("checked %0d pixel writes in %0d cycles, %0d mismatches",
			pixels_checked, cycles, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lpr_pkg.sv
rtl/lpr_cfg.sv
rtl/lpr_step.sv
rtl/lpr_addr.sv
rtl/line_pixel_rasterizer.sv
dv/line_pixel_rasterizer_test.sv
